// ----- src/clx_pkg.sv -----
package clx_pkg;

    // Default build values
    localparam int TEXT_MAX_DEF    = 127;
    localparam int LINE_BITS_DEF   = 24;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int KIND_W      = 5;
    localparam int KW_COUNT    = 9;
    localparam int KW_MAX_LEN  = 6;
    localparam int QUEUE_DEPTH = 4;

    // Token kinds
    localparam logic [KIND_W-1:0] K_END     = 5'd0;
    localparam logic [KIND_W-1:0] K_UNKNOWN = 5'd1;
    localparam logic [KIND_W-1:0] K_IDENT   = 5'd2;
    localparam logic [KIND_W-1:0] K_NUMBER  = 5'd3;
    localparam logic [KIND_W-1:0] K_KEYWORD0 = 5'd4;
    localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd13;
    localparam logic [KIND_W-1:0] K_EQ      = 5'd14;
    localparam logic [KIND_W-1:0] K_NEQ     = 5'd15;
    localparam logic [KIND_W-1:0] K_LT      = 5'd16;
    localparam logic [KIND_W-1:0] K_LE      = 5'd17;
    localparam logic [KIND_W-1:0] K_GT      = 5'd18;
    localparam logic [KIND_W-1:0] K_GE      = 5'd19;
    localparam logic [KIND_W-1:0] K_PLUS    = 5'd20;
    localparam logic [KIND_W-1:0] K_MINUS   = 5'd21;
    localparam logic [KIND_W-1:0] K_STAR    = 5'd22;
    localparam logic [KIND_W-1:0] K_SLASH   = 5'd23;
    localparam logic [KIND_W-1:0] K_LPAREN  = 5'd24;
    localparam logic [KIND_W-1:0] K_RPAREN  = 5'd25;
    localparam logic [KIND_W-1:0] K_LBRACE  = 5'd26;
    localparam logic [KIND_W-1:0] K_RBRACE  = 5'd27;
    localparam logic [KIND_W-1:0] K_SEMI    = 5'd28;
    localparam logic [KIND_W-1:0] K_COMMA   = 5'd29;

    // Characters with special meaning
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    typedef enum logic [3:0] {
        M_IDLE       = 4'd0,
        M_IDENT      = 4'd1,
        M_NUMBER     = 4'd2,
        M_EQ         = 4'd3,
        M_BANG       = 4'd4,
        M_LT         = 4'd5,
        M_GT         = 4'd6,
        M_SLASH      = 4'd7,
        M_LINE_CMT   = 4'd8,
        M_BLOCK_CMT  = 4'd9,
        M_BLOCK_STAR = 4'd10
    } mode_t;

    // Keyword spellings: int float void if else while for return static
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h66, 8'h6C, 8'h6F, 8'h61, 8'h74, 8'h00},
        '{8'h76, 8'h6F, 8'h69, 8'h64, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6C, 8'h73, 8'h65, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6C, 8'h65, 8'h00},
        '{8'h66, 8'h6F, 8'h72, 8'h00, 8'h00, 8'h00},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6E},
        '{8'h73, 8'h74, 8'h61, 8'h74, 8'h69, 8'h63}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd6
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // Kind of a byte that forms a token by itself
    function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            CH_PLUS:  k = K_PLUS;
            CH_MINUS: k = K_MINUS;
            CH_STAR:  k = K_STAR;
            CH_LPAR:  k = K_LPAREN;
            CH_RPAR:  k = K_RPAREN;
            CH_LBRC:  k = K_LBRACE;
            CH_RBRC:  k = K_RBRACE;
            CH_SEMI:  k = K_SEMI;
            CH_COMMA: k = K_COMMA;
            default:  k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    // Drop keywords that cannot match once byte c lands at position pos
    function automatic logic [KW_COUNT-1:0] cand_update(input logic [KW_COUNT-1:0] cand,
                                                        input logic [7:0] pos,
                                                        input logic [7:0] c);
        logic [KW_COUNT-1:0] r;
        r = cand;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (pos >= 8'(KW_LEN[k])) begin
                r[k] = 1'b0;
            end
            else if (KW_TEXT[k][pos[2:0]] != c) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // First surviving keyword of full length, else identifier
    function automatic logic [KIND_W-1:0] ident_kind(input logic [KW_COUNT-1:0] cand,
                                                     input logic [7:0] len);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (cand[i] && len == 8'(KW_LEN[i])) begin
                k = KIND_W'(int'(K_KEYWORD0) + i);
            end
        end
        return k;
    endfunction

endpackage

// ----- src/clx_if.sv -----
interface clx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       end_of_input;

    modport source (output valid, output char_byte, output end_of_input, input ready);
    modport sink   (input valid, input char_byte, input end_of_input, output ready);
endinterface

interface clx_tok_if #(
    parameter int LINE_BITS   = 24,
    parameter int OFFSET_BITS = 32,
    parameter int LEN_BITS    = 7
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             token_kind;
    logic [LINE_BITS-1:0]   token_line;
    logic [OFFSET_BITS-1:0] token_offset;
    logic [LEN_BITS-1:0]    token_length;
    logic                   last_of_run;

    modport source (output valid, output token_kind, output token_line, output token_offset,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_line, input token_offset,
                    input token_length, input last_of_run, output ready);
endinterface

interface clx_pair_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/clx_scan.sv -----
module clx_scan
    import clx_pkg::*;
#(
    parameter int TEXT_MAX    = TEXT_MAX_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    clx_in_if.sink       chars,
    clx_pair_if.source   pairs
);
    localparam int LEN_BITS = $clog2(TEXT_MAX + 1);
    localparam int TOK_W    = KIND_W + LINE_BITS + OFFSET_BITS + LEN_BITS;

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [OFFSET_BITS-1:0] soff_reg, soff_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [KW_COUNT-1:0]    cand_reg, cand_next;

    logic [7:0]           c;
    logic                 accept;
    logic [LINE_BITS-1:0] line_inc;
    logic [LEN_BITS-1:0]  len_inc;

    // byte seen from between tokens
    logic                idle_emit, idle_begin, idle_nl;
    mode_t               idle_mode;
    logic [KIND_W-1:0]   idle_kind;
    logic [LEN_BITS-1:0] idle_len;
    logic [KW_COUNT-1:0] idle_cand;

    logic              apply_idle, emit_pend, emit_idle, emit_end, pend_twin;
    logic [KIND_W-1:0] pend_kind;
    logic [LEN_BITS-1:0] pend_len;
    logic [TOK_W-1:0]  pend_tok, idle_tok, end_tok;

    assign c        = chars.char_byte;
    assign accept   = chars.valid && chars.ready;
    assign line_inc = (line_reg == '1) ? line_reg : line_reg + LINE_BITS'(1);
    assign len_inc  = (len_reg < LEN_BITS'(TEXT_MAX)) ? len_reg + LEN_BITS'(1) : len_reg;

    always_comb
    begin
        idle_emit  = 1'b0;
        idle_begin = 1'b0;
        idle_nl    = 1'b0;
        idle_mode  = M_IDLE;
        idle_kind  = single_kind(c);
        idle_len   = '0;
        idle_cand  = cand_reg;
        if (c == CH_NL) begin
            idle_nl = 1'b1;
        end
        else if (is_space(c)) begin
            idle_mode = M_IDLE;
        end
        else if (is_alpha(c)) begin
            idle_mode  = M_IDENT;
            idle_begin = 1'b1;
            idle_len   = LEN_BITS'(1);
            idle_cand  = cand_update('1, 8'd0, c);
        end
        else if (is_digit(c)) begin
            idle_mode  = M_NUMBER;
            idle_begin = 1'b1;
            idle_len   = LEN_BITS'(1);
        end
        else begin
            unique case (c)
                CH_EQ:    begin idle_mode = M_EQ;    idle_begin = 1'b1; end
                CH_BANG:  begin idle_mode = M_BANG;  idle_begin = 1'b1; end
                CH_LT:    begin idle_mode = M_LT;    idle_begin = 1'b1; end
                CH_GT:    begin idle_mode = M_GT;    idle_begin = 1'b1; end
                CH_SLASH: begin idle_mode = M_SLASH; idle_begin = 1'b1; end
                default:  idle_emit = 1'b1;
            endcase
        end
    end

    // Kind of the pending token, plain or joined with a following '='
    always_comb
    begin
        pend_len = LEN_BITS'(1);
        unique case (mode_reg)
            M_IDENT:  begin pend_kind = ident_kind(cand_reg, 8'(len_reg)); pend_len = len_reg; end
            M_NUMBER: begin pend_kind = K_NUMBER; pend_len = len_reg; end
            M_EQ:     pend_kind = pend_twin ? K_EQ  : K_ASSIGN;
            M_BANG:   pend_kind = pend_twin ? K_NEQ : K_UNKNOWN;
            M_LT:     pend_kind = pend_twin ? K_LE  : K_LT;
            M_GT:     pend_kind = pend_twin ? K_GE  : K_GT;
            default:  pend_kind = K_SLASH;
        endcase
        if (pend_twin) begin
            pend_len = LEN_BITS'(2);
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        off_next   = off_reg;
        sline_next = sline_reg;
        soff_next  = soff_reg;
        len_next   = len_reg;
        cand_next  = cand_reg;
        apply_idle = 1'b0;
        emit_pend  = 1'b0;
        emit_end   = 1'b0;
        pend_twin  = 1'b0;
        if (chars.end_of_input) begin
            // flush, emit end, return to reset state
            unique case (mode_reg)
                M_IDENT, M_NUMBER, M_EQ, M_BANG, M_LT, M_GT, M_SLASH: emit_pend = 1'b1;
                default: emit_pend = 1'b0;
            endcase
            emit_end   = 1'b1;
            mode_next  = M_IDLE;
            line_next  = LINE_BITS'(1);
            off_next   = '0;
            sline_next = LINE_BITS'(1);
            soff_next  = '0;
            len_next   = '0;
            cand_next  = '1;
        end
        else begin
            off_next = off_reg + OFFSET_BITS'(1);
            unique case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c)) begin
                        cand_next = cand_update(cand_reg, 8'(len_reg), c);
                        len_next  = len_inc;
                    end
                    else begin
                        emit_pend  = 1'b1;
                        apply_idle = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(c)) begin
                        len_next = len_inc;
                    end
                    else begin
                        emit_pend  = 1'b1;
                        apply_idle = 1'b1;
                    end
                end
                M_EQ, M_BANG, M_LT, M_GT:
                begin
                    emit_pend = 1'b1;
                    if (c == CH_EQ) begin
                        pend_twin = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else begin
                        apply_idle = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (c == CH_SLASH) begin
                        mode_next = M_LINE_CMT;
                    end
                    else if (c == CH_STAR) begin
                        mode_next = M_BLOCK_CMT;
                    end
                    else begin
                        emit_pend  = 1'b1;
                        apply_idle = 1'b1;
                    end
                end
                M_LINE_CMT:
                begin
                    if (c == CH_NL) begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                M_BLOCK_CMT:
                begin
                    if (c == CH_STAR) begin
                        mode_next = M_BLOCK_STAR;
                    end
                    else if (c == CH_NL) begin
                        line_next = line_inc;
                    end
                end
                M_BLOCK_STAR:
                begin
                    if (c == CH_SLASH) begin
                        mode_next = M_IDLE;
                    end
                    else if (c != CH_STAR) begin
                        if (c == CH_NL) begin
                            line_next = line_inc;
                        end
                        mode_next = M_BLOCK_CMT;
                    end
                end
                default:
                begin
                    apply_idle = 1'b1;
                end
            endcase
            if (apply_idle) begin
                mode_next = idle_mode;
                if (idle_nl) begin
                    line_next = line_inc;
                end
                if (idle_begin) begin
                    sline_next = line_reg;
                    soff_next  = off_reg;
                    len_next   = idle_len;
                    cand_next  = idle_cand;
                end
            end
        end
    end

    assign emit_idle = apply_idle && idle_emit;

    assign pend_tok = {pend_kind, sline_reg, soff_reg, pend_len};
    assign idle_tok = {idle_kind, line_reg, off_reg, LEN_BITS'(1)};
    assign end_tok  = {K_END, line_reg, off_reg, LEN_BITS'(0)};

    // Pair: {two tokens, second token, first token}
    assign pairs.data  = {emit_pend && (emit_idle || emit_end),
                          emit_end ? end_tok : idle_tok,
                          emit_pend ? pend_tok : (emit_end ? end_tok : idle_tok)};
    assign pairs.valid = chars.valid && (emit_pend || emit_idle || emit_end);
    assign chars.ready = pairs.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= M_IDLE;
            line_reg  <= LINE_BITS'(1);
            off_reg   <= '0;
            sline_reg <= LINE_BITS'(1);
            soff_reg  <= '0;
            len_reg   <= '0;
            cand_reg  <= '1;
        end
        else if (accept) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            off_reg   <= off_next;
            sline_reg <= sline_next;
            soff_reg  <= soff_next;
            len_reg   <= len_next;
            cand_reg  <= cand_next;
        end
    end

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count dropped to zero");

    a_len_capped: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_BITS'(TEXT_MAX))
        else $error("token length above cap");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.end_of_input) |=> (mode_reg == M_IDLE && off_reg == '0
                                             && line_reg == LINE_BITS'(1)))
        else $error("stream end did not restart the scanner");

endmodule

// ----- src/clx_queue.sv -----
module clx_queue
    import clx_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    clx_pair_if.sink    wr,
    clx_pair_if.source  rd
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign wr.ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign rd.valid = count_reg != '0;
    assign rd.data  = entry_reg[rd_ptr_reg];
    assign push     = wr.valid && wr.ready;
    assign pop      = rd.valid && rd.ready;

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/clx_emit.sv -----
module clx_emit
    import clx_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF,
    parameter int LEN_BITS    = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    clx_pair_if.sink    pairs,
    clx_tok_if.source   tokens
);
    localparam int TOK_W = KIND_W + LINE_BITS + OFFSET_BITS + LEN_BITS;

    logic                   valid_reg, valid_next;
    logic                   phase_reg, phase_next;
    logic [KIND_W-1:0]      kind_reg;
    logic [LINE_BITS-1:0]   line_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [LEN_BITS-1:0]    len_reg;
    logic                   last_reg;

    logic             slot_free, load, head_two;
    logic [TOK_W-1:0] head_tok;

    assign head_two  = pairs.data[2*TOK_W];
    assign head_tok  = phase_reg ? pairs.data[2*TOK_W-1:TOK_W] : pairs.data[TOK_W-1:0];
    assign slot_free = !valid_reg || tokens.ready;
    assign load      = slot_free && pairs.valid;
    // Release the pair once its last token moves into the output register
    assign pairs.ready = slot_free && (phase_reg || !head_two);

    always_comb
    begin
        valid_next = valid_reg;
        phase_next = phase_reg;
        if (slot_free) begin
            valid_next = pairs.valid;
        end
        if (load) begin
            phase_next = !phase_reg && head_two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg <= head_tok[TOK_W-1 -: KIND_W];
            line_reg <= head_tok[LEN_BITS+OFFSET_BITS +: LINE_BITS];
            off_reg  <= head_tok[LEN_BITS +: OFFSET_BITS];
            len_reg  <= head_tok[LEN_BITS-1:0];
            last_reg <= phase_reg || !head_two;
        end
    end

    assign tokens.valid        = valid_reg;
    assign tokens.token_kind   = kind_reg;
    assign tokens.token_line   = line_reg;
    assign tokens.token_offset = off_reg;
    assign tokens.token_length = len_reg;
    assign tokens.last_of_run  = last_reg;

endmodule

// ----- src/c_subset_lexer_unit.sv -----
// Streaming tokenizer for a small C subset.
// chars:  one source byte per item (char_byte), or an item with
//         end_of_input set that flushes any pending token and emits an end
//         token; char_byte is ignored on such an item.
// tokens: one item per token with kind, start line, start byte offset,
//         length (saturating at TEXT_MAX) and last_of_run, which marks the
//         last token caused by one input item.
// Throughput: one input item per cycle while the queue has room. An item
//   may cause zero, one or two tokens; the output side sends one token per
//   cycle, so a run of bytes that each close two tokens is limited to one
//   token per cycle there. Path: a token is stored in a queue entry and
//   then loaded into the output register; a second token closed by the
//   same byte is loaded after it.
// Structure: the scanner classifies each byte in the cycle it is accepted
//   and pushes a token pair into a four-entry queue; the emitter drains
//   pairs one token at a time into the output register.
// Stalls: when tokens.ready is low the output register holds; the queue
//   absorbs up to four pairs before chars.ready drops.
// Reset: line 1, offset 0, no pending token; the same state is restored
//   after every end-of-input item, ready for the next stream.
module c_subset_lexer_unit
    import clx_pkg::*;
#(
    parameter int TEXT_MAX    = TEXT_MAX_DEF,
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    clx_in_if.sink      chars,
    clx_tok_if.source   tokens
);
    localparam int LEN_BITS = $clog2(TEXT_MAX + 1);
    localparam int TOK_W    = KIND_W + LINE_BITS + OFFSET_BITS + LEN_BITS;
    localparam int PAIR_W   = 2 * TOK_W + 1;

    // scanner to queue, queue to emitter
    clx_pair_if #(.WIDTH(PAIR_W)) scan_pairs ();
    clx_pair_if #(.WIDTH(PAIR_W)) queued_pairs ();

    clx_scan #(
        .TEXT_MAX    (TEXT_MAX),
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .chars (chars),
        .pairs (scan_pairs.source)
    );

    clx_queue #(
        .WIDTH (PAIR_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (scan_pairs.sink),
        .rd    (queued_pairs.source)
    );

    clx_emit #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .LEN_BITS    (LEN_BITS)
    ) u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .pairs  (queued_pairs.sink),
        .tokens (tokens)
    );

endmodule
